/* src/tbds_pkg.sv */
// ----------------------------------------------------------------------------
// tbds_pkg
// shared constants, codes and controller/datapath types for the shaper
// ----------------------------------------------------------------------------
package tbds_pkg;

	localparam int QUEUE_DEPTH = 32;
	localparam int DIRECTIONS  = 2;
	localparam int MAX_FRAME   = 1518;

	localparam int SLOT_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W  = SLOT_W + 1;
	localparam int DIR_W  = 1;
	localparam int ADDR_W = DIR_W + SLOT_W;

	localparam int RATE_W  = 20;
	localparam int DELAY_W = 14;
	localparam int LOSS_W  = 14;
	localparam int LEN_W   = 11;
	localparam int TAG_W   = 16;
	localparam int TIME_W  = 48;
	localparam int ELAP_W  = 20;
	localparam int TOK_W   = 48;
	localparam int QB_W    = 16;
	localparam int IDX_W   = 3;
	localparam int QLIM_W  = 30;
	localparam int DUS_W   = 24;
	localparam int COST_W  = 21;
	localparam int BURST_W = 38;

	typedef enum logic [1:0] {
		VERDICT_ACCEPT = 2'd0,
		VERDICT_LOST   = 2'd1,
		VERDICT_LIMIT  = 2'd2,
		VERDICT_FULL   = 2'd3
	} verdict_t;

	localparam logic [IDX_W-1:0] REG_RATE0  = 3'd0;
	localparam logic [IDX_W-1:0] REG_RATE1  = 3'd1;
	localparam logic [IDX_W-1:0] REG_DELAY0 = 3'd2;
	localparam logic [IDX_W-1:0] REG_DELAY1 = 3'd3;
	localparam logic [IDX_W-1:0] REG_LOSS0  = 3'd4;
	localparam logic [IDX_W-1:0] REG_LOSS1  = 3'd5;

	localparam logic FUNC_ARRIVAL = 1'b0;
	localparam logic FUNC_TICK    = 1'b1;
	localparam logic KIND_VERDICT = 1'b0;
	localparam logic KIND_RELEASE = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic take;      // latch the input request
		logic prep;      // register products derived from the rate and delay
		logic arr_done;  // decide the arrival and load the result
		logic refill;    // refill and cap tokens
		logic rd;        // read the head descriptor
		logic pop;       // release head into the pending slot
		logic flush;     // end of tick, push pending with last set
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_tick;
		logic eligible;
		logic pend_valid;
		logic out_free;
	} status_t;

endpackage

/* src/tbds_if.sv */
// ----------------------------------------------------------------------------
// tbds_if
// request, result and configuration channels of the shaper
// ----------------------------------------------------------------------------
interface tbds_req_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic        direction;
	logic [10:0] packet_length;
	logic [15:0] packet_tag;
	logic [13:0] loss_draw;
	logic [47:0] now_us;
	logic [19:0] elapsed_us;

	modport source (output valid, func, direction, packet_length, packet_tag,
		loss_draw, now_us, elapsed_us, input ready);
	modport sink (input valid, func, direction, packet_length, packet_tag,
		loss_draw, now_us, elapsed_us, output ready);
endinterface

interface tbds_rsp_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic        out_direction;
	logic [1:0]  verdict;
	logic [10:0] out_length;
	logic [15:0] out_tag;
	logic        last;

	modport source (output valid, kind, out_direction, verdict, out_length,
		out_tag, last, input ready);
	modport sink (input valid, kind, out_direction, verdict, out_length,
		out_tag, last, output ready);
endinterface

interface tbds_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [19:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* src/tbds_ctrl.sv */
// ----------------------------------------------------------------------------
// tbds_ctrl
// sequencer for arrival decisions and tick release walks
// ----------------------------------------------------------------------------
module tbds_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  tbds_pkg::status_t st,
	output tbds_pkg::cmd_t    cmd
);
	import tbds_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_A_PREP, S_A_DEC, S_T_MUL, S_T_REF, S_T_RD, S_T_EV
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   hold;

	assign req_ready = !busy_q;
	// pending release can only move on when the result register frees
	assign hold = st.pend_valid && !st.out_free;

	always_comb begin
		cmd          = '0;
		cmd.take     = (state_q == S_IDLE) && req_valid;
		cmd.prep     = (state_q == S_A_PREP) || (state_q == S_T_MUL);
		cmd.arr_done = (state_q == S_A_DEC) && st.out_free;
		cmd.refill   = (state_q == S_T_REF);
		cmd.rd       = (state_q == S_T_RD);
		cmd.pop      = (state_q == S_T_EV) && st.eligible && !hold;
		cmd.flush    = (state_q == S_T_EV) && !st.eligible && !hold;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: if (req_valid) begin
					busy_q  <= 1'b1;
					state_q <= S_A_PREP;
				end
				S_A_PREP: state_q <= st.is_tick ? S_T_MUL : S_A_DEC;
				S_A_DEC: if (st.out_free) begin
					busy_q  <= 1'b0;
					state_q <= S_IDLE;
				end
				S_T_MUL: state_q <= S_T_REF;
				S_T_REF: state_q <= S_T_RD;
				S_T_RD:  state_q <= S_T_EV;
				S_T_EV: if (!hold) begin
					if (st.eligible) begin
						state_q <= S_T_RD;
					end else begin
						busy_q  <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					busy_q  <= 1'b0;
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

/* src/tbds_dp.sv */
// ----------------------------------------------------------------------------
// tbds_dp
// registers, descriptor memory, token arithmetic and result register
// ----------------------------------------------------------------------------
module tbds_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tbds_pkg::cmd_t               cmd,
	output tbds_pkg::status_t            st,
	input  logic                         req_func,
	input  logic                         req_dir,
	input  logic [tbds_pkg::LEN_W-1:0]   req_len,
	input  logic [tbds_pkg::TAG_W-1:0]   req_tag,
	input  logic [tbds_pkg::LOSS_W-1:0]  req_draw,
	input  logic [tbds_pkg::TIME_W-1:0]  req_now,
	input  logic [tbds_pkg::ELAP_W-1:0]  req_elapsed,
	input  logic                         cfg_we,
	input  logic [tbds_pkg::IDX_W-1:0]   cfg_idx,
	input  logic [tbds_pkg::RATE_W-1:0]  cfg_data,
	output logic                         rsp_valid,
	input  logic                         rsp_ready,
	output logic                         rsp_kind,
	output logic                         rsp_dir,
	output logic [1:0]                   rsp_verdict,
	output logic [tbds_pkg::LEN_W-1:0]   rsp_len,
	output logic [tbds_pkg::TAG_W-1:0]   rsp_tag,
	output logic                         rsp_last
);
	import tbds_pkg::*;

	localparam int ENT_W = LEN_W + TIME_W + TAG_W;

	// configuration
	logic [RATE_W-1:0]  rate_q  [DIRECTIONS];
	logic [DELAY_W-1:0] delay_q [DIRECTIONS];
	logic [LOSS_W-1:0]  loss_q  [DIRECTIONS];

	// per-direction state
	logic [TOK_W-1:0]  token_q [DIRECTIONS];
	logic [QB_W-1:0]   qb_q    [DIRECTIONS];
	logic [SLOT_W-1:0] head_q  [DIRECTIONS];
	logic [CNT_W-1:0]  count_q [DIRECTIONS];

	// latched request
	logic               func_q, dir_q;
	logic [LEN_W-1:0]   len_q;
	logic [TAG_W-1:0]   tag_q;
	logic [LOSS_W-1:0]  draw_q;
	logic [TIME_W-1:0]  now_q;
	logic [ELAP_W-1:0]  elapsed_q;

	// products
	logic [QLIM_W-1:0]  qlim_q;
	logic [RATE_W+ELAP_W-1:0] prod_q;
	logic [BURST_W-1:0] burst_q;
	logic [DUS_W-1:0]   dus_q;

	// descriptor memory
	logic [ENT_W-1:0]   mem [DIRECTIONS*QUEUE_DEPTH];
	logic [ENT_W-1:0]   rd_q;
	logic               mem_we;
	logic [ADDR_W-1:0]  wr_addr;

	// pending release and result register
	logic               pend_valid_q;
	logic [LEN_W-1:0]   pend_len_q;
	logic [TAG_W-1:0]   pend_tag_q;

	logic [RATE_W-1:0]  rate_c;
	logic [DELAY_W-1:0] delay_c;
	logic [LOSS_W-1:0]  loss_c;
	logic [TOK_W-1:0]   tok_c;
	logic [QB_W-1:0]    qb_c;
	logic [SLOT_W-1:0]  head_c;
	logic [CNT_W-1:0]   cnt_c;
	logic [10:0]        qfac;
	logic               lost, limited, full;
	verdict_t           verdict_c;
	logic [LEN_W-1:0]   hd_len;
	logic [TIME_W-1:0]  hd_time;
	logic [TAG_W-1:0]   hd_tag;
	logic [TIME_W-1:0]  age;
	logic [COST_W-1:0]  cost;
	logic               age_ok, tok_ok;
	logic [TOK_W-1:0]   refill_sum;
	logic               out_free;

	assign rate_c  = rate_q[dir_q];
	assign delay_c = delay_q[dir_q];
	assign loss_c  = loss_q[dir_q];
	assign tok_c   = token_q[dir_q];
	assign qb_c    = qb_q[dir_q];
	assign head_c  = head_q[dir_q];
	assign cnt_c   = count_q[dir_q];

	always_comb begin
		if (rate_c > RATE_W'(1000))      qfac = 11'd250;
		else if (rate_c > RATE_W'(100))  qfac = 11'd500;
		else                             qfac = 11'd1000;
	end

	assign lost    = (loss_c != '0) && (draw_q <= loss_c);
	assign limited = (rate_c != '0) &&
		(QLIM_W'(qb_c) + QLIM_W'(MAX_FRAME) >= qlim_q);
	assign full    = (cnt_c >= CNT_W'(QUEUE_DEPTH));

	always_comb begin
		if (lost)         verdict_c = VERDICT_LOST;
		else if (limited) verdict_c = VERDICT_LIMIT;
		else if (full)    verdict_c = VERDICT_FULL;
		else              verdict_c = VERDICT_ACCEPT;
	end

	assign {hd_len, hd_time, hd_tag} = rd_q;
	assign age    = now_q - hd_time;
	assign cost   = COST_W'(hd_len) * COST_W'(1000);
	assign age_ok = (dus_q == '0) || (age >= TIME_W'(dus_q));
	assign tok_ok = (rate_c == '0) || (tok_c > TOK_W'(cost));
	assign refill_sum = tok_c + TOK_W'(prod_q);
	assign out_free = !rsp_valid || rsp_ready;

	assign st.is_tick    = (func_q == FUNC_TICK);
	assign st.eligible   = (cnt_c != '0) && age_ok && tok_ok;
	assign st.pend_valid = pend_valid_q;
	assign st.out_free   = out_free;

	assign mem_we  = cmd.arr_done && (verdict_c == VERDICT_ACCEPT);
	assign wr_addr = {dir_q, head_c + cnt_c[SLOT_W-1:0]};

	always_ff @(posedge clk) begin
		if (mem_we) mem[wr_addr] <= {len_q, now_q, tag_q};
		if (cmd.rd) rd_q <= mem[{dir_q, head_c}];
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			func_q    <= req_func;
			dir_q     <= req_dir;
			len_q     <= req_len;
			tag_q     <= req_tag;
			draw_q    <= req_draw;
			now_q     <= req_now;
			elapsed_q <= req_elapsed;
		end
		if (cmd.prep) begin
			qlim_q  <= QLIM_W'(rate_c) * QLIM_W'(qfac);
			prod_q  <= (RATE_W+ELAP_W)'(rate_c) * (RATE_W+ELAP_W)'(elapsed_q);
			burst_q <= BURST_W'(rate_c) * BURST_W'(125000) + BURST_W'(2000000);
			dus_q   <= DUS_W'(delay_c) * DUS_W'(1000);
		end
		if (cmd.pop) begin
			pend_len_q <= hd_len;
			pend_tag_q <= hd_tag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < DIRECTIONS; d++) begin
				rate_q[d]  <= '0;
				delay_q[d] <= '0;
				loss_q[d]  <= '0;
				token_q[d] <= '0;
				qb_q[d]    <= '0;
				head_q[d]  <= '0;
				count_q[d] <= '0;
			end
			pend_valid_q <= 1'b0;
			rsp_valid    <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_RATE0:  rate_q[0]  <= cfg_data;
					REG_RATE1:  rate_q[1]  <= cfg_data;
					REG_DELAY0: delay_q[0] <= cfg_data[DELAY_W-1:0];
					REG_DELAY1: delay_q[1] <= cfg_data[DELAY_W-1:0];
					REG_LOSS0:  loss_q[0]  <= cfg_data[LOSS_W-1:0];
					REG_LOSS1:  loss_q[1]  <= cfg_data[LOSS_W-1:0];
					default: ;
				endcase
			end
			if (rsp_valid && rsp_ready) rsp_valid <= 1'b0;

			if (cmd.arr_done) begin
				rsp_valid   <= 1'b1;
				rsp_kind    <= KIND_VERDICT;
				rsp_dir     <= dir_q;
				rsp_verdict <= verdict_c;
				rsp_len     <= len_q;
				rsp_tag     <= tag_q;
				rsp_last    <= 1'b1;
				if (verdict_c == VERDICT_ACCEPT) begin
					count_q[dir_q] <= cnt_c + CNT_W'(1);
					qb_q[dir_q]    <= qb_c + QB_W'(len_q);
				end
			end

			if (cmd.refill)
				token_q[dir_q] <= (refill_sum > TOK_W'(burst_q)) ? TOK_W'(burst_q) : refill_sum;

			if ((cmd.pop || cmd.flush) && pend_valid_q) begin
				rsp_valid   <= 1'b1;
				rsp_kind    <= KIND_RELEASE;
				rsp_dir     <= dir_q;
				rsp_verdict <= VERDICT_ACCEPT;
				rsp_len     <= pend_len_q;
				rsp_tag     <= pend_tag_q;
				rsp_last    <= cmd.flush;
			end
			if (cmd.flush) pend_valid_q <= 1'b0;

			if (cmd.pop) begin
				pend_valid_q   <= 1'b1;
				head_q[dir_q]  <= head_c + SLOT_W'(1);
				count_q[dir_q] <= cnt_c - CNT_W'(1);
				qb_q[dir_q]    <= qb_c - QB_W'(hd_len);
				if (rate_c != '0) token_q[dir_q] <= tok_c - TOK_W'(cost);
			end
		end
	end
endmodule

/* src/token_bucket_delay_shaper.sv */
// ----------------------------------------------------------------------------
// token_bucket_delay_shaper
// two-direction link emulator: random loss, byte limit, added delay and
// token bucket shaping over a descriptor fifo per direction
// ----------------------------------------------------------------------------
//  channel | role   | moves
//  item    | sink   | arrival or tick request
//  result  | source | verdict or released packet, last marks end of request
//  cfg     | sink   | register write, index 0..5
//
//  an arrival's verdict is loaded once the result register is free; a tick
//  refills tokens, then reads and checks the head for each released packet
//  and once more for the final head check; the walk is set by the one read
//  port of the descriptor memory and the head check after each read
//  reset clears counters, tokens and registers; the descriptor memory is
//  not cleared, only occupied slots are ever released
//  a stalled result register holds the sequencer; cfg is always ready
module token_bucket_delay_shaper (
	input logic  clk,
	input logic  arst_n,
	tbds_req_if.sink   item,
	tbds_rsp_if.source result,
	tbds_cfg_if.sink   cfg
);
	import tbds_pkg::*;

	cmd_t    cmd;
	status_t st;

	// config writes never stall
	assign cfg.ready = 1'b1;

	// sequencer: arrival decision and release walk
	tbds_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (item.valid),
		.req_ready (item.ready),
		.st        (st),
		.cmd       (cmd)
	);

	// datapath: state, descriptor memory, arithmetic, result register
	tbds_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.req_func    (item.func),
		.req_dir     (item.direction),
		.req_len     (item.packet_length),
		.req_tag     (item.packet_tag),
		.req_draw    (item.loss_draw),
		.req_now     (item.now_us),
		.req_elapsed (item.elapsed_us),
		.cfg_we      (cfg.valid),
		.cfg_idx     (cfg.index),
		.cfg_data    (cfg.data),
		.rsp_valid   (result.valid),
		.rsp_ready   (result.ready),
		.rsp_kind    (result.kind),
		.rsp_dir     (result.out_direction),
		.rsp_verdict (result.verdict),
		.rsp_len     (result.out_length),
		.rsp_tag     (result.out_tag),
		.rsp_last    (result.last)
	);
endmodule

/* src/tbds_checker.sv */
// ----------------------------------------------------------------------------
// tbds_checker
// port-level checks of the shaper, bound to the top level
// ----------------------------------------------------------------------------
module tbds_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       out_kind,
	input logic [1:0] out_verdict,
	input logic       out_last
);
	import tbds_pkg::*;

	// a pending result is not withdrawn
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// one request at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while busy");

	// an arrival's verdict carries last
	a_verdict_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_kind == KIND_VERDICT) |-> out_last)
		else $error("verdict without last");

	// releases carry a zero verdict
	a_release_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_kind == KIND_RELEASE) |-> (out_verdict == VERDICT_ACCEPT))
		else $error("release with nonzero verdict");
endmodule

bind token_bucket_delay_shaper tbds_checker u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (item.valid),
	.in_ready    (item.ready),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.out_kind    (result.kind),
	.out_verdict (result.verdict),
	.out_last    (result.last)
);
